/* hw/rtl/csq_pkg.sv */
package csq_pkg;

  localparam int unsigned OpcodeWidth = 3;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned FieldWidth  = 32;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_START   = 3'd0,
    OP_ADVANCE = 3'd1,
    OP_INSERT  = 3'd2,
    OP_ATTACH  = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_QUERY   = 3'd5
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Broadcast to every cell: which way the row moves in this cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

/* hw/rtl/cursor_sequence_store_top.sv */
// Channel   Direction  Handshake                  Payload
// request   in         in_valid_i / in_ready_o    opcode_i, value_i
// result    out        out_valid_o / out_ready_i  current_value_o, item_valid_o,
//                                                 item_count_o, status_o
//
// A request updates the row of entry cells, the count and the cursor at the edge
// where it is accepted; its result is read from the updated row into the output
// register when free. One request per cycle is sustained while results are taken.
// A stalled result holds the read stage, and the input then stalls too.
// Reset clears the count, the cursor and the valid flags; entries need no reset.
module cursor_sequence_store_top
  import csq_pkg::*;
#(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OpcodeWidth-1:0] opcode_i,
  input  logic [FieldWidth-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FieldWidth-1:0] current_value_o,
  output logic                  item_valid_o,
  output logic [CntW-1:0]       item_count_o,
  output logic [StatusWidth-1:0] status_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned SW   = (VALUE_WIDTH < FieldWidth) ? VALUE_WIDTH : FieldWidth;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cursor_q, cursor_d;
  logic            pend_q;
  status_e         pend_status_q, status_c;
  logic            out_valid_q;
  logic [FieldWidth-1:0] cur_q;
  logic            item_valid_q;
  logic [CntW-1:0] item_count_q;
  status_e         status_q;

  logic            accept;
  logic            load_out;
  logic            has_c;
  logic            full_c;
  cell_ctl_t       ctl_c;
  logic [CntW-1:0] pos_c;
  logic [IdxW-1:0] pos_idx;
  logic [SW-1:0]   value_c;
  logic [SW-1:0]   cell_data [CAPACITY];
  logic [IdxW-1:0] rd_idx;
  logic [SW-1:0]   rd_data;
  op_e             op_c;

  assign load_out   = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || load_out;
  assign accept     = in_valid_i && in_ready_o;

  assign op_c    = op_e'(opcode_i);
  assign value_c = value_i[SW-1:0];
  assign has_c   = cursor_q < count_q;
  assign full_c  = count_q >= CapCnt;
  assign pos_idx = pos_c[IdxW-1:0];

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    status_c = ST_OK;
    ctl_c    = '0;
    pos_c    = '0;
    if (accept) begin
      case (op_c)
        OP_START: begin
          cursor_d = '0;
        end
        OP_ADVANCE: begin
          if (has_c) begin
            cursor_d = cursor_q + 1'b1;
          end
        end
        OP_INSERT: begin
          if (full_c) begin
            status_c = ST_FULL;
          end else begin
            // With no current item the value goes to the front.
            pos_c     = has_c ? cursor_q : '0;
            cursor_d  = pos_c;
            count_d   = count_q + 1'b1;
            ctl_c.ins = 1'b1;
          end
        end
        OP_ATTACH: begin
          if (full_c) begin
            status_c = ST_FULL;
          end else begin
            if (count_q == '0) begin
              pos_c = '0;
            end else if (has_c) begin
              pos_c = cursor_q + 1'b1;
            end else begin
              pos_c = count_q;
            end
            cursor_d  = pos_c;
            count_d   = count_q + 1'b1;
            ctl_c.ins = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (count_q == '0) begin
            status_c = ST_EMPTY;
          end else begin
            // With no current item the last one goes, leaving the cursor past the end.
            pos_c     = has_c ? cursor_q : count_q - 1'b1;
            cursor_d  = pos_c;
            count_d   = count_q - 1'b1;
            ctl_c.rem = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SW-1:0] left_c, right_c;
    if (i == 0) begin : g_first
      assign left_c = value_c;
    end else begin : g_mid_l
      assign left_c = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_c = cell_data[i];
    end else begin : g_mid_r
      assign right_c = cell_data[i+1];
    end
    csq_cell #(
      .Idx  (i),
      .IdxW (IdxW),
      .W    (SW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_c),
      .pos_i   (pos_idx),
      .value_i (value_c),
      .left_i  (left_c),
      .right_i (right_c),
      .data_o  (cell_data[i])
    );
  end

  assign rd_idx  = has_c ? cursor_q[IdxW-1:0] : '0;
  assign rd_data = (count_q != '0) ? cell_data[rd_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      cursor_q      <= '0;
      pend_q        <= 1'b0;
      pend_status_q <= ST_OK;
      out_valid_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      if (accept) begin
        pend_q        <= 1'b1;
        pend_status_q <= status_c;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      cur_q        <= FieldWidth'(rd_data);
      item_valid_q <= has_c;
      item_count_q <= count_q;
      status_q     <= pend_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_value_o = cur_q;
  assign item_valid_o    = item_valid_q;
  assign item_count_o    = item_count_q;
  assign status_o        = status_q;

endmodule

/* hw/rtl/csq_cell.sv */
module csq_cell
  import csq_pkg::*;
#(
  parameter int unsigned Idx  = 0,
  parameter int unsigned IdxW = 4,
  parameter int unsigned W    = 32
) (
  input  logic            clk_i,
  input  cell_ctl_t       ctl_i,
  input  logic [IdxW-1:0] pos_i,
  input  logic [W-1:0]    value_i,
  input  logic [W-1:0]    left_i,
  input  logic [W-1:0]    right_i,
  output logic [W-1:0]    data_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic [W-1:0] data_q, data_d;

  // On insert the cells above the gap take their lower neighbor; on remove the
  // cells from the gap upward take their upper neighbor.
  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (MyIdx == pos_i) begin
        data_d = value_i;
      end else if (MyIdx > pos_i) begin
        data_d = left_i;
      end
    end else if (ctl_i.rem) begin
      if (MyIdx >= pos_i) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
